### rtl/core/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// No dependencies; every other file of the block but htd_node_mem refers to this one.
package htd_pkg;

  localparam int NodeCountDef  = 1024;
  localparam int SymbolBitsDef = 9;

  localparam int IdxW     = 10;
  localparam int SymW     = 9;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  localparam logic [ModeW-1:0] MODE_LOAD    = 2'd0;
  localparam logic [ModeW-1:0] MODE_DECODE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_RESTART = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ROOT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_END  = 1'b1;

  localparam logic [SymW-1:0] EndSymbolRst = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_CHILD,
    ST_ROOT
  } walk_state_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  node_index;
    logic [IdxW-1:0]  zero_child;
    logic [IdxW-1:0]  one_child;
    logic             leaf_mark;
    logic [SymW-1:0]  leaf_symbol;
    logic             code_bit;
    logic             bits_exhausted;
  } item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            is_end;
    logic            is_error;
  } result_t;

endpackage

### rtl/core/htd_node_mem.sv
// Node table storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module htd_node_mem #(
  parameter int Depth = 1024,
  parameter int Width = 30
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/htd_out_buf.sv
// Two-entry result buffer between the walk engine and the output channel.
// Depends on htd_pkg for the result type.
module htd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  htd_pkg::result_t  push_res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output htd_pkg::result_t  out_res
);

  logic [1:0]       count_r, count_nxt;
  htd_pkg::result_t head_r, head_nxt;
  htd_pkg::result_t tail_r, tail_nxt;
  logic             pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r != 2'd2);
  assign out_res   = head_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10: begin
        count_nxt = count_r + 2'd1;
        if (count_r == 2'd0) begin
          head_nxt = push_res;
        end else begin
          tail_nxt = push_res;
        end
      end
      2'b01: begin
        count_nxt = count_r - 2'd1;
        head_nxt  = tail_r;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_res;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

### rtl/core/htd_walk.sv
// Tree walk engine: input holding stage, config registers, node caches, sequencer.
// Depends on htd_pkg; drives htd_node_mem and feeds htd_out_buf.
module htd_walk #(
  parameter int NODE_COUNT  = htd_pkg::NodeCountDef,
  parameter int SYMBOL_BITS = htd_pkg::SymbolBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  htd_pkg::item_t                in_item,
  input  logic                          cfg_wr_en,
  input  logic [htd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [htd_pkg::CfgDataW-1:0]  cfg_data,
  output logic                          mem_wr_en,
  output logic [$clog2(NODE_COUNT)-1:0] mem_wr_addr,
  output logic [2*htd_pkg::IdxW+SYMBOL_BITS:0] mem_wr_data,
  output logic                          mem_rd_en,
  output logic [$clog2(NODE_COUNT)-1:0] mem_rd_addr,
  input  logic [2*htd_pkg::IdxW+SYMBOL_BITS:0] mem_rd_data,
  input  logic                          buf_room,
  output logic                          push,
  output htd_pkg::result_t              push_res
);

  localparam int IW = htd_pkg::IdxW;
  localparam int SB = SYMBOL_BITS;
  localparam int EW = 2 * IW + SB + 1;
  localparam int AW = $clog2(NODE_COUNT);

  // entry layout: {symbol, leaf, one child, zero child}
  function automatic logic ent_leaf(input logic [EW-1:0] e);
    ent_leaf = e[2*IW];
  endfunction

  function automatic logic [SB-1:0] ent_sym(input logic [EW-1:0] e);
    ent_sym = e[EW-1 -: SB];
  endfunction

  function automatic logic in_range(input logic [IW-1:0] idx);
    in_range = (32'(idx) < 32'(NODE_COUNT));
  endfunction

  htd_pkg::walk_state_t state_r, state_nxt;
  htd_pkg::item_t       hold_r;
  logic                 hold_vld_r;
  logic [IW-1:0]        root_r;
  logic [htd_pkg::SymW-1:0] end_r;
  logic [IW-1:0]        cur_node_r, cur_node_nxt;
  logic [EW-1:0]        cur_ent_r, cur_ent_nxt;
  logic                 cur_vld_r, cur_vld_nxt;
  logic [EW-1:0]        root_ent_r, root_ent_nxt;
  logic                 root_vld_r, root_vld_nxt;
  logic                 stopped_r, stopped_nxt;
  logic [IW-1:0]        child_r, child_nxt;
  logic                 bit_r, bit_nxt;
  logic                 exh_r, exh_nxt;
  logic                 rd_oor_r, rd_oor_nxt;

  logic          take, is_decode, is_restart;
  logic          miss, rst_hit, rst_miss;
  logic          do_proc, proc_leaf, proc_err, proc_child;
  logic [EW-1:0] rd_ent, proc_ent, root_eff_ent, load_ent, emit_ent;
  logic          proc_bit, proc_exh, root_fill, root_eff_vld;
  logic          emit, go_root;
  logic [IW-1:0] rd_idx, child_idx;

  assign rd_ent = rd_oor_r ? '0 : mem_rd_data;

  assign take       = hold_vld_r && (state_r == htd_pkg::ST_IDLE) && buf_room;
  assign in_stall   = hold_vld_r && !take;
  assign is_decode  = take && (hold_r.mode == htd_pkg::MODE_DECODE) && !stopped_r;
  assign is_restart = take && (hold_r.mode == htd_pkg::MODE_RESTART);
  assign miss       = is_decode && !cur_vld_r;
  assign rst_hit    = is_restart && root_vld_r;
  assign rst_miss   = is_restart && !root_vld_r;

  // the current node's entry is either cached or has just been read
  assign do_proc    = (is_decode && cur_vld_r) || (state_r == htd_pkg::ST_CUR);
  assign proc_ent   = (state_r == htd_pkg::ST_CUR) ? rd_ent : cur_ent_r;
  assign proc_bit   = (state_r == htd_pkg::ST_CUR) ? bit_r : hold_r.code_bit;
  assign proc_exh   = (state_r == htd_pkg::ST_CUR) ? exh_r : hold_r.bits_exhausted;
  assign proc_leaf  = do_proc && ent_leaf(proc_ent);
  assign proc_err   = do_proc && !ent_leaf(proc_ent) && proc_exh;
  assign proc_child = do_proc && !ent_leaf(proc_ent) && !proc_exh;
  assign child_idx  = proc_bit ? proc_ent[2*IW-1 -: IW] : proc_ent[IW-1:0];

  // any read that lands on the root also refreshes the root cache
  assign root_fill = ((state_r == htd_pkg::ST_CUR) && (cur_node_r == root_r)) ||
                     ((state_r == htd_pkg::ST_CHILD) && (child_r == root_r)) ||
                     (state_r == htd_pkg::ST_ROOT);
  assign root_eff_ent = root_fill ? rd_ent : root_ent_r;
  assign root_eff_vld = root_fill || root_vld_r;

  assign load_ent = {SB'(hold_r.leaf_symbol), hold_r.leaf_mark,
                     hold_r.one_child, hold_r.zero_child};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htd_pkg::ST_IDLE: begin
        if (miss) begin
          state_nxt = htd_pkg::ST_CUR;
        end else if (rst_miss) begin
          state_nxt = htd_pkg::ST_ROOT;
        end else if (proc_child) begin
          state_nxt = htd_pkg::ST_CHILD;
        end
      end
      htd_pkg::ST_CUR: begin
        state_nxt = proc_child ? htd_pkg::ST_CHILD : htd_pkg::ST_IDLE;
      end
      htd_pkg::ST_CHILD: state_nxt = htd_pkg::ST_IDLE;
      htd_pkg::ST_ROOT:  state_nxt = htd_pkg::ST_IDLE;
      default:           state_nxt = htd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_node_nxt = cur_node_r;
    cur_ent_nxt  = cur_ent_r;
    cur_vld_nxt  = cur_vld_r;
    root_ent_nxt = root_ent_r;
    root_vld_nxt = root_vld_r;
    stopped_nxt  = stopped_r;
    child_nxt    = child_r;
    bit_nxt      = bit_r;
    exh_nxt      = exh_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = AW'(hold_r.node_index);
    mem_wr_data  = load_ent;
    mem_rd_en    = 1'b0;
    rd_idx       = cur_node_r;
    emit         = 1'b0;
    emit_ent     = proc_ent;
    go_root      = 1'b0;
    push         = 1'b0;
    push_res     = '0;

    if (root_fill) begin
      root_ent_nxt = rd_ent;
      root_vld_nxt = 1'b1;
    end

    unique case (state_r)
      htd_pkg::ST_IDLE: begin
        if (take && (hold_r.mode == htd_pkg::MODE_LOAD) && in_range(hold_r.node_index)) begin
          mem_wr_en = 1'b1;
          if (hold_r.node_index == cur_node_r) begin
            cur_ent_nxt = load_ent;
            cur_vld_nxt = 1'b1;
          end
          if (hold_r.node_index == root_r) begin
            root_ent_nxt = load_ent;
            root_vld_nxt = 1'b1;
          end
        end
        if (is_restart) begin
          cur_node_nxt = root_r;
          stopped_nxt  = 1'b0;
          cur_ent_nxt  = root_ent_r;
          cur_vld_nxt  = root_vld_r;
        end
        if (rst_hit && ent_leaf(root_ent_r)) begin
          emit     = 1'b1;
          emit_ent = root_ent_r;
        end
        if (rst_miss) begin
          mem_rd_en = 1'b1;
          rd_idx    = root_r;
        end
        if (miss) begin
          mem_rd_en = 1'b1;
          rd_idx    = cur_node_r;
          bit_nxt   = hold_r.code_bit;
          exh_nxt   = hold_r.bits_exhausted;
        end
      end
      htd_pkg::ST_CUR: begin
        cur_ent_nxt = rd_ent;
        cur_vld_nxt = 1'b1;
      end
      htd_pkg::ST_CHILD: begin
        if (ent_leaf(rd_ent)) begin
          emit     = 1'b1;
          emit_ent = rd_ent;
        end else begin
          cur_node_nxt = child_r;
          cur_ent_nxt  = rd_ent;
          cur_vld_nxt  = 1'b1;
        end
      end
      htd_pkg::ST_ROOT: begin
        cur_ent_nxt = rd_ent;
        cur_vld_nxt = 1'b1;
        if (ent_leaf(rd_ent)) begin
          emit     = 1'b1;
          emit_ent = rd_ent;
        end
      end
      default: begin
      end
    endcase

    if (proc_leaf) begin
      emit     = 1'b1;
      emit_ent = proc_ent;
    end
    if (proc_err) begin
      push              = 1'b1;
      push_res.is_error = 1'b1;
      stopped_nxt       = 1'b1;
      go_root           = 1'b1;
    end
    if (proc_child) begin
      mem_rd_en = 1'b1;
      rd_idx    = child_idx;
      child_nxt = child_idx;
    end

    if (emit) begin
      push            = 1'b1;
      push_res.symbol = htd_pkg::SymW'(ent_sym(emit_ent));
      push_res.is_end = (ent_sym(emit_ent) == SB'(end_r));
      if (push_res.is_end) begin
        stopped_nxt = 1'b1;
      end
      go_root = 1'b1;
    end
    if (go_root) begin
      cur_node_nxt = root_r;
      cur_ent_nxt  = root_eff_ent;
      cur_vld_nxt  = root_eff_vld;
    end
  end

  assign mem_rd_addr = AW'(rd_idx);
  assign rd_oor_nxt  = mem_rd_en ? !in_range(rd_idx) : rd_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= htd_pkg::ST_IDLE;
      hold_vld_r <= 1'b0;
      cur_node_r <= '0;
      cur_vld_r  <= 1'b0;
      root_vld_r <= 1'b0;
      stopped_r  <= 1'b0;
      root_r     <= '0;
      end_r      <= htd_pkg::EndSymbolRst;
    end else begin
      state_r    <= state_nxt;
      cur_node_r <= cur_node_nxt;
      cur_vld_r  <= cur_vld_nxt;
      root_vld_r <= root_vld_nxt;
      stopped_r  <= stopped_nxt;
      if (in_valid && !in_stall) begin
        hold_vld_r <= 1'b1;
      end else if (take) begin
        hold_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          htd_pkg::CFG_ROOT: begin
            root_r     <= cfg_data;
            root_vld_r <= 1'b0;
          end
          htd_pkg::CFG_END: end_r <= cfg_data[htd_pkg::SymW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_r <= in_item;
    end
    cur_ent_r  <= cur_ent_nxt;
    root_ent_r <= root_ent_nxt;
    child_r    <= child_nxt;
    bit_r      <= bit_nxt;
    exh_r      <= exh_nxt;
    rd_oor_r   <= rd_oor_nxt;
  end

endmodule

### rtl/core/huffman_tree_decode.sv
// Huffman tree decoder, one coded bit per decode item, node table in on-chip RAM.
// Item path: input holding register, current node fetch on a cache miss, child entry read
// through the RAM read port, result buffer. A decode bit stepping to a child holds off the
// next item until that read; a load does not, nor a restart unless the root must be fetched.
// Reset (rst_n low, synchronous): walk at node 0, not stopped, root_index 0, end_symbol 256,
// node caches and output buffer empty; the node table keeps whatever it held.
module huffman_tree_decode #(
  parameter int NODE_COUNT  = htd_pkg::NodeCountDef,
  parameter int SYMBOL_BITS = htd_pkg::SymbolBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [htd_pkg::ModeW-1:0]     in_mode,
  input  logic [htd_pkg::IdxW-1:0]      in_node_index,
  input  logic [htd_pkg::IdxW-1:0]      in_zero_child,
  input  logic [htd_pkg::IdxW-1:0]      in_one_child,
  input  logic                          in_leaf_mark,
  input  logic [htd_pkg::SymW-1:0]      in_leaf_symbol,
  input  logic                          in_code_bit,
  input  logic                          in_bits_exhausted,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [htd_pkg::SymW-1:0]      out_symbol,
  output logic                          out_is_end,
  output logic                          out_is_error,
  // configuration writes: index 0 root_index, 1 end_symbol
  input  logic                          cfg_wr_en,
  input  logic [htd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [htd_pkg::CfgDataW-1:0]  cfg_data
);

  // Entry: {symbol, leaf mark, one child, zero child}
  localparam int EW = 2 * htd_pkg::IdxW + SYMBOL_BITS + 1;
  localparam int AW = $clog2(NODE_COUNT);

  htd_pkg::item_t   in_item;
  htd_pkg::result_t push_res, out_res;
  logic             push, buf_room;
  logic             mem_wr_en, mem_rd_en;
  logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
  logic [EW-1:0]    mem_wr_data, mem_rd_data;

  assign in_item.mode           = in_mode;
  assign in_item.node_index     = in_node_index;
  assign in_item.zero_child     = in_zero_child;
  assign in_item.one_child      = in_one_child;
  assign in_item.leaf_mark      = in_leaf_mark;
  assign in_item.leaf_symbol    = in_leaf_symbol;
  assign in_item.code_bit       = in_code_bit;
  assign in_item.bits_exhausted = in_bits_exhausted;

  // Walk engine: holds one incoming item while the previous one finishes, caches the
  // current node and root entries so a steady bit stream needs only the child read.
  htd_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .buf_room    (buf_room),
    .push        (push),
    .push_res    (push_res)
  );

  // Node table RAM, registered read
  htd_node_mem #(
    .Depth (NODE_COUNT),
    .Width (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Result buffer decouples a stalled output from the walk
  htd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .room      (buf_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_symbol   = out_res.symbol;
  assign out_is_end   = out_res.is_end;
  assign out_is_error = out_res.is_error;

endmodule

### test/tb_huffman_tree_decode.sv
// Self-checking testbench for the Huffman tree decoder: directed table, then random trees.
// Depends on htd_pkg for widths, mode and register codes, and on the huffman_tree_decode RTL.
module tb_huffman_tree_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import htd_pkg::*;

  localparam int NODES         = NodeCountDef;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;     // keep margin over the worst case item latency
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 250;
  localparam int NUM_PHASES    = 12;
  localparam int BODY_ITEMS    = 140;
  localparam int MAX_TREE      = 64;

  // mode 3 has no name in the package; the block ignores it
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  // how a directed row gets its expectation
  typedef enum {EXP_MODEL, EXP_NONE, EXP_RESULT} exp_kind_t;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  node;
    logic [IdxW-1:0]  zc;
    logic [IdxW-1:0]  oc;
    logic             leaf;
    logic [SymW-1:0]  sym;
    logic             bitv;
    logic             exh;
    exp_kind_t        kind;
    logic [SymW-1:0]  e_sym;
    logic             e_end;
    logic             e_err;
  } dir_row_t;

  // DUT signals, all inputs known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ModeW-1:0] in_mode = '0;
  logic [IdxW-1:0]  in_node_index = '0;
  logic [IdxW-1:0]  in_zero_child = '0;
  logic [IdxW-1:0]  in_one_child = '0;
  logic             in_leaf_mark = 1'b0;
  logic [SymW-1:0]  in_leaf_symbol = '0;
  logic             in_code_bit = 1'b0;
  logic             in_bits_exhausted = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [SymW-1:0]  out_symbol;
  logic             out_is_end;
  logic             out_is_error;
  logic             cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // shadow of the decoder: node table, walk position, stop flag, registers
  bit [IdxW-1:0] tbl_zero    [NODES];
  bit [IdxW-1:0] tbl_one     [NODES];
  bit            tbl_leaf    [NODES];
  bit [SymW-1:0] tbl_sym     [NODES];
  bit            tbl_written [NODES];   // entries never written must never be read
  bit [IdxW-1:0] walk_node   = '0;
  bit            walk_halted = 1'b0;
  bit [IdxW-1:0] root_reg    = '0;
  bit [SymW-1:0] end_reg     = EndSymbolRst;

  result_t pending_results[$];   // decoded symbols not yet seen on the output
  int      mismatches  = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      cycle_count = 0;

  // receiver long hold-off, armed once by the main sequence
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  // directed table: extremes, errors, end symbol, leaf root, load while walking
  dir_row_t dir_rows [26] = '{
    '{MODE_LOAD,    0,    1,    1023, 0, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_LOAD,    1,    0,    0,    1, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_LOAD,    1023, 1023, 1023, 1, 511, 1, 1, EXP_MODEL,  0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   0, 0, EXP_RESULT, 0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 0, EXP_RESULT, 511, 0, 0},
    // bits ran out at an internal node
    '{MODE_DECODE,  0,    0,    0,    0, 0,   0, 1, EXP_RESULT, 0,   0, 1},
    // stopped: decode does nothing
    '{MODE_DECODE,  1023, 1023, 1023, 1, 511, 1, 0, EXP_NONE,   0,   0, 0},
    '{MODE_UNUSED,  1023, 1023, 1023, 1, 511, 1, 1, EXP_NONE,   0,   0, 0},
    '{MODE_RESTART, 0,    0,    0,    0, 0,   0, 0, EXP_NONE,   0,   0, 0},
    '{MODE_LOAD,    2,    0,    0,    1, 256, 0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_LOAD,    0,    2,    3,    0, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_LOAD,    3,    1,    1023, 0, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    // reset end symbol reached
    '{MODE_DECODE,  0,    0,    0,    0, 0,   0, 0, EXP_RESULT, 256, 1, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 0, EXP_NONE,   0,   0, 0},
    '{MODE_RESTART, 0,    0,    0,    0, 0,   0, 0, EXP_NONE,   0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 0, EXP_MODEL,  0,   0, 0},
    // root becomes a leaf while the walk sits on it
    '{MODE_LOAD,    0,    0,    0,    1, 5,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   1, 1, EXP_MODEL,  0,   0, 0},
    '{MODE_RESTART, 0,    0,    0,    0, 0,   0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_LOAD,    0,    0,    0,    1, 256, 0, 0, EXP_MODEL,  0,   0, 0},
    '{MODE_RESTART, 0,    0,    0,    0, 0,   0, 0, EXP_RESULT, 256, 1, 0},
    '{MODE_DECODE,  0,    0,    0,    0, 0,   0, 0, EXP_NONE,   0,   0, 0},
    '{MODE_LOAD,    0,    2,    3,    0, 0,   0, 0, EXP_MODEL,  0,   0, 0}
  };

  huffman_tree_decode i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_node_index     (in_node_index),
    .in_zero_child     (in_zero_child),
    .in_one_child      (in_one_child),
    .in_leaf_mark      (in_leaf_mark),
    .in_leaf_symbol    (in_leaf_symbol),
    .in_code_bit       (in_code_bit),
    .in_bits_exhausted (in_bits_exhausted),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_is_end        (out_is_end),
    .out_is_error      (out_is_error),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Leaf reached: give its symbol, check for end, return to root.
  function automatic bit emit_symbol(input bit [IdxW-1:0] n, output result_t res);
    res.symbol   = tbl_sym[n];
    res.is_end   = (tbl_sym[n] == end_reg);
    res.is_error = 1'b0;
    walk_node    = root_reg;
    if (res.is_end) walk_halted = 1'b1;
    return 1'b1;
  endfunction

  // Applies one accepted item to the shadow; returns 1 when it yields a result.
  function automatic bit predict_walk(input item_t it, output result_t res);
    bit [IdxW-1:0] child;
    res = '0;
    case (it.mode)
      MODE_LOAD: begin
        tbl_zero[it.node_index]    = it.zero_child;
        tbl_one[it.node_index]     = it.one_child;
        tbl_leaf[it.node_index]    = it.leaf_mark;
        tbl_sym[it.node_index]     = it.leaf_symbol;
        tbl_written[it.node_index] = 1'b1;
        return 1'b0;
      end
      MODE_RESTART: begin
        walk_node   = root_reg;
        walk_halted = 1'b0;
        if (tbl_leaf[walk_node]) return emit_symbol(walk_node, res);
        return 1'b0;
      end
      MODE_DECODE: begin
        if (walk_halted) return 1'b0;
        // a leaf under the walk ignores the bit and the exhausted flag
        if (tbl_leaf[walk_node]) return emit_symbol(walk_node, res);
        if (it.bits_exhausted) begin
          res.is_error = 1'b1;
          walk_halted  = 1'b1;
          walk_node    = root_reg;
          return 1'b1;
        end
        child = it.code_bit ? tbl_one[walk_node] : tbl_zero[walk_node];
        if (tbl_leaf[child]) return emit_symbol(child, res);
        walk_node = child;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item with random sender gaps, waits for acceptance, then predicts.
  task automatic offer(input item_t it, input exp_kind_t kind, input result_t typed);
    result_t res;
    bit      has;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_node_index     <= it.node_index;
    in_zero_child     <= it.zero_child;
    in_one_child      <= it.one_child;
    in_leaf_mark      <= it.leaf_mark;
    in_leaf_symbol    <= it.leaf_symbol;
    in_code_bit       <= it.code_bit;
    in_bits_exhausted <= it.bits_exhausted;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = predict_walk(it, res);
    case (kind)
      EXP_MODEL:  if (has) pending_results.push_back(res);
      EXP_RESULT: pending_results.push_back(typed);
      default: ;
    endcase
  endtask

  // Stop offering, let every expected result drain, then allow for items still in flight.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: check against the oldest expectation, then pick next stall.
  always @(posedge clk) begin : rx_side
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, symbol", 16'(out_symbol), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_symbol !== want.symbol)
          report_mismatch("symbol", 16'(out_symbol), 16'(want.symbol));
        if (out_is_end !== want.is_end)
          report_mismatch("is_end", 16'(out_is_end), 16'(want.is_end));
        if (out_is_error !== want.is_error)
          report_mismatch("is_error", 16'(out_is_error), 16'(want.is_error));
      end
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
  end

  // Long receiver hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_seq
    item_t            it;
    result_t          typed;
    logic [63:0]      rnd;
    int unsigned      r;
    bit [IdxW-1:0]    child;
    logic [IdxW-1:0]  nid [MAX_TREE];
    bit               nleaf [MAX_TREE];
    int               kid0 [MAX_TREE];
    int               kid1 [MAX_TREE];
    bit               used [NODES];
    int               cnt;
    int               leaves;
    int               j;
    logic [IdxW-1:0]  pick;
    logic [SymW-1:0]  end_val;

    tx_idle_pct = 21;
    rx_idle_pct = 77;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset register values ----
    foreach (dir_rows[i]) begin
      it = '0;
      it.mode           = dir_rows[i].mode;
      it.node_index     = dir_rows[i].node;
      it.zero_child     = dir_rows[i].zc;
      it.one_child      = dir_rows[i].oc;
      it.leaf_mark      = dir_rows[i].leaf;
      it.leaf_symbol    = dir_rows[i].sym;
      it.code_bit       = dir_rows[i].bitv;
      it.bits_exhausted = dir_rows[i].exh;
      typed.symbol   = dir_rows[i].e_sym;
      typed.is_end   = dir_rows[i].e_end;
      typed.is_error = dir_rows[i].e_err;
      offer(it, dir_rows[i].kind, typed);
    end

    // ---- random part: one fresh tree per phase ----
    typed = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // idling: sender light / receiver heavy, then swapped, then none
      if (ph < 4) begin
        tx_idle_pct = 21;
        rx_idle_pct = 77;
      end else if (ph < 8) begin
        tx_idle_pct = 77;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // end symbol: both extremes first, random later
      if (ph == 0) end_val = '0;
      else if (ph == 1) end_val = '1;
      else end_val = SymW'($urandom);

      // leaf count: a lone leaf root once, one large tree, small otherwise
      if (ph == 2) leaves = 1;
      else if (ph == 5) leaves = MAX_TREE / 2;
      else leaves = $urandom_range(12, 2);

      // grow a full binary tree on distinct random indices; root at 0 and 1023 once
      foreach (used[k]) used[k] = 1'b0;
      if (ph == 0) nid[0] = '0;
      else if (ph == 1) nid[0] = '1;
      else nid[0] = IdxW'($urandom);
      used[nid[0]] = 1'b1;
      nleaf[0] = 1'b1;
      cnt = 1;
      for (int k = 1; k < leaves; k++) begin
        do j = $urandom_range(cnt - 1); while (!nleaf[j]);
        for (int c = 0; c < 2; c++) begin
          do pick = IdxW'($urandom); while (used[pick]);
          used[pick] = 1'b1;
          nid[cnt + c]   = pick;
          nleaf[cnt + c] = 1'b1;
        end
        nleaf[j] = 1'b0;
        kid0[j]  = cnt;
        kid1[j]  = cnt + 1;
        cnt += 2;
      end

      for (int n = 0; n < cnt; n++) begin
        rnd = {$urandom, $urandom};
        it = rnd[$bits(item_t)-1:0];
        it.mode       = MODE_LOAD;
        it.node_index = nid[n];
        it.leaf_mark  = nleaf[n];
        if (!nleaf[n]) begin
          it.zero_child = nid[kid0[n]];
          it.one_child  = nid[kid1[n]];
        end else if ($urandom_range(4) == 0) begin
          it.leaf_symbol = end_val;
        end
        offer(it, EXP_MODEL, typed);
      end

      // registers change only with the block idle
      wait_for_quiet();
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_ROOT;
      cfg_data  <= nid[0];
      @(posedge clk);
      root_reg = nid[0];
      cfg_index <= CFG_END;
      cfg_data  <= {1'($urandom), end_val};   // top bit is outside the register
      @(posedge clk);
      end_reg = end_val;
      cfg_wr_en <= 1'b0;

      // with no idling, hold the receiver off and keep offering items
      if (ph == 8) hold_req <= 1'b1;

      it = '0;
      it.mode = MODE_RESTART;
      offer(it, EXP_MODEL, typed);

      // mostly bit items walking the tree; restarts after a stop; some noise
      for (int b = 0; b < BODY_ITEMS; b++) begin
        r   = $urandom_range(99);
        rnd = {$urandom, $urandom};
        it  = rnd[$bits(item_t)-1:0];
        if (walk_halted) begin
          if (r < 85) it.mode = MODE_RESTART;
          else if (r < 95) it.mode = MODE_DECODE;
          else it.mode = MODE_UNUSED;
        end else if (r < 80 && tbl_written[walk_node]) begin
          it.mode = MODE_DECODE;
          it.bits_exhausted = ($urandom_range(99) < 3);
          // steer away from children that were never loaded
          if (!tbl_leaf[walk_node] && !it.bits_exhausted) begin
            child = it.code_bit ? tbl_one[walk_node] : tbl_zero[walk_node];
            if (!tbl_written[child]) begin
              it.code_bit = ~it.code_bit;
              child = it.code_bit ? tbl_one[walk_node] : tbl_zero[walk_node];
              if (!tbl_written[child]) it.bits_exhausted = 1'b1;
            end
          end
        end else if (r < 88) begin
          it.mode = MODE_RESTART;
        end else if (r < 92) begin
          it.mode = MODE_UNUSED;
        end else begin
          it.mode = MODE_LOAD;   // stray load, may land on the live tree
        end
        offer(it, EXP_MODEL, typed);
      end
    end

    wait_for_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/htd_pkg.sv
rtl/core/htd_node_mem.sv
rtl/core/htd_out_buf.sv
rtl/core/htd_walk.sv
rtl/core/huffman_tree_decode.sv
test/tb_huffman_tree_decode.sv
